[rtl/core/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and character decode for the bracket stack checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int unsigned SCORE_W  = 63;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned KIND_W   = 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	// Line status codes
	localparam logic [STATUS_W-1:0] ST_BALANCED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CORRUPT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_OPEN_P  = 8'h28; // (
	localparam logic [7:0] CH_OPEN_S  = 8'h5B; // [
	localparam logic [7:0] CH_OPEN_C  = 8'h7B; // {
	localparam logic [7:0] CH_OPEN_A  = 8'h3C; // <
	localparam logic [7:0] CH_CLOSE_P = 8'h29; // )
	localparam logic [7:0] CH_CLOSE_S = 8'h5D; // ]
	localparam logic [7:0] CH_CLOSE_C = 8'h7D; // }
	localparam logic [7:0] CH_CLOSE_A = 8'h3E; // >

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
	} kind_dec_t;

	typedef struct packed {
		logic              clr;
		logic              en;
		logic [KIND_W-1:0] kind;
	} score_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_WALK = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	function automatic kind_dec_t open_decode(input logic [7:0] ch);
		kind_dec_t d;
		d = '0;
		case (ch)
			CH_OPEN_P: d = '{hit: 1'b1, kind: 2'd0};
			CH_OPEN_S: d = '{hit: 1'b1, kind: 2'd1};
			CH_OPEN_C: d = '{hit: 1'b1, kind: 2'd2};
			CH_OPEN_A: d = '{hit: 1'b1, kind: 2'd3};
			default:   d = '0;
		endcase
		return d;
	endfunction

	function automatic kind_dec_t close_decode(input logic [7:0] ch);
		kind_dec_t d;
		d = '0;
		case (ch)
			CH_CLOSE_P: d = '{hit: 1'b1, kind: 2'd0};
			CH_CLOSE_S: d = '{hit: 1'b1, kind: 2'd1};
			CH_CLOSE_C: d = '{hit: 1'b1, kind: 2'd2};
			CH_CLOSE_A: d = '{hit: 1'b1, kind: 2'd3};
			default:    d = '0;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/bsc_stack_ram.sv]
// ----------------------------------------------------------------------------
// bsc_stack_ram
// Bracket kind store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsc_stack_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/bsc_score_acc.sv]
// ----------------------------------------------------------------------------
// bsc_score_acc
// Base-5 completion score accumulator with saturation at the score maximum.
// ----------------------------------------------------------------------------
module bsc_score_acc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsc_pkg::score_ctl_t           ctl,
	output logic [bsc_pkg::SCORE_W-1:0]   score,
	output logic                          sat
);
	import bsc_pkg::*;

	localparam int unsigned EXT_W = SCORE_W + 3;

	logic [SCORE_W-1:0] score_q;
	logic               sat_q;
	logic [EXT_W-1:0]   ext;
	logic [EXT_W-1:0]   nxt;
	logic               nxt_ovf;

	// score * 5 + (kind + 1); anything above bit 62 means saturation
	always_comb begin
		ext     = EXT_W'(score_q);
		nxt     = (ext << 2) + ext + EXT_W'(ctl.kind) + EXT_W'(1);
		nxt_ovf = |nxt[EXT_W-1:SCORE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			sat_q   <= 1'b0;
		end else if (ctl.clr) begin
			score_q <= '0;
			sat_q   <= 1'b0;
		end else if (ctl.en && !sat_q) begin
			if (nxt_ovf) begin
				score_q <= SCORE_MAX;
				sat_q   <= 1'b1;
			end else begin
				score_q <= nxt[SCORE_W-1:0];
			end
		end
	end

	assign score = score_q;
	assign sat   = sat_q;

endmodule

[rtl/core/bracket_stack_checker.sv]
// ----------------------------------------------------------------------------
// bracket_stack_checker
// Per-line balanced bracket checker with base-5 completion score.
// ----------------------------------------------------------------------------
// One character is taken per item. A closing bracket that pops the stack
// moves on to S_CMP, as the top kind comes back registered from the stack
// memory. On an incomplete line a newline walks the stack top down in
// S_WALK over the single read port of the stack memory, stopping early
// once the score saturates, and loads the result from S_FIN; a balanced,
// corrupt or overflowed line loads it straight from S_IDLE. A finished
// result waits in the output register while further brackets are taken;
// only a newline waits for it to drain. The stack needs no clearing at reset.
// ----------------------------------------------------------------------------
module bracket_stack_checker #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     char_code,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bsc_pkg::STATUS_W-1:0]   line_status,
	output logic [bsc_pkg::SCORE_W-1:0]    completion_score
);
	import bsc_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic                corrupt_q;
	logic                overflow_q;
	logic [KIND_W-1:0]   kind_q;
	logic [AW-1:0]       left_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SCORE_W-1:0]  score_q;

	kind_dec_t           od;
	kind_dec_t           cd;
	logic                is_nl;
	logic                acc_in;
	logic                out_free;
	logic                out_load;
	logic                live;
	logic                full;
	logic [CW-1:0]       count_m1;

	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [1:0]          ram_rdata;

	score_ctl_t          sc_ctl;
	logic [SCORE_W-1:0]  acc_score;
	logic                acc_sat;

	always_comb begin
		od       = open_decode(char_code);
		cd       = close_decode(char_code);
		is_nl    = (char_code == CH_NEWLINE);
		out_free = !out_valid_q || !out_stall;
		in_stall = (state_q != S_IDLE) || (is_nl && !out_free);
		acc_in   = in_valid && !in_stall;
		live     = !corrupt_q && !overflow_q;
		full     = (count_q == CW'(STACK_DEPTH));
		count_m1 = count_q - CW'(1);
		out_load = ((state_q == S_IDLE) && acc_in && is_nl && !(live && (count_q != '0)))
			|| ((state_q == S_FIN) && out_free);
	end

	// Stack memory accesses
	always_comb begin
		ram_we    = acc_in && od.hit && live && !full;
		ram_re    = 1'b0;
		ram_raddr = count_m1[AW-1:0];
		if (state_q == S_WALK) begin
			ram_re    = (left_q != '0) && !acc_sat;
			ram_raddr = left_q - AW'(1);
		end else if (acc_in && live && (count_q != '0)) begin
			ram_re = cd.hit || is_nl;
		end
	end

	bsc_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (od.kind),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sc_ctl.clr  = acc_in && is_nl;
		sc_ctl.en   = (state_q == S_WALK);
		sc_ctl.kind = ram_rdata;
	end

	bsc_score_acc u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sc_ctl),
		.score  (acc_score),
		.sat    (acc_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			corrupt_q   <= 1'b0;
			overflow_q  <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_in && od.hit && live) begin
						if (full) begin
							overflow_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end else if (acc_in && cd.hit && live) begin
						if (count_q == '0) begin
							corrupt_q <= 1'b1;
						end else begin
							count_q <= count_m1;
							state_q <= S_CMP;
						end
					end else if (acc_in && is_nl) begin
						count_q    <= '0;
						corrupt_q  <= 1'b0;
						overflow_q <= 1'b0;
						if (live && (count_q != '0)) begin
							// walk the remaining entries top down
							left_q  <= count_m1[AW-1:0];
							state_q <= S_WALK;
						end
					end
				end
				S_CMP: begin
					if (ram_rdata != kind_q) begin
						corrupt_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if ((left_q == '0) || acc_sat) begin
						state_q <= S_FIN;
					end else begin
						left_q <= left_q - AW'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc_in && cd.hit) begin
			kind_q <= cd.kind;
		end
		if (state_q == S_IDLE && acc_in && is_nl && !(live && (count_q != '0))) begin
			if (corrupt_q) begin
				status_q <= ST_CORRUPT;
			end else if (overflow_q) begin
				status_q <= ST_OVERFLOW;
			end else begin
				status_q <= ST_BALANCED;
			end
			score_q <= '0;
		end else if (state_q == S_FIN && out_free) begin
			status_q <= acc_sat ? ST_SATURATED : ST_INCOMPLETE;
			score_q  <= acc_score;
		end
	end

	assign out_valid        = out_valid_q;
	assign line_status      = status_q;
	assign completion_score = score_q;

endmodule

[rtl/core/bsc_checker.sv]
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the bracket stack checker results, bound to the top.
// ----------------------------------------------------------------------------
module bsc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     char_code,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [bsc_pkg::STATUS_W-1:0]   line_status,
	input  logic [bsc_pkg::SCORE_W-1:0]    completion_score
);
	import bsc_pkg::*;

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_status)
			&& $stable(completion_score))
		else $error("stalled result changed");

	// a stalled character stays offered unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(char_code))
		else $error("stalled character changed");

	a_zero_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((line_status == ST_BALANCED) || (line_status == ST_CORRUPT)
			|| (line_status == ST_OVERFLOW)) |-> completion_score == '0)
		else $error("nonzero score on a line without completion");

	a_sat_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_status == ST_SATURATED) |-> completion_score == SCORE_MAX)
		else $error("saturated line without maximum score");

	a_incomplete_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_status == ST_INCOMPLETE) |-> completion_score != '0)
		else $error("incomplete line with zero score");

endmodule

bind bracket_stack_checker bsc_checker u_bsc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.char_code        (char_code),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.line_status      (line_status),
	.completion_score (completion_score)
);
